@@ rtl/xcl_pkg.sv @@
// Shared widths, defaults and the cell control bundle of the cross-correlation lag search.
package xcl_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int PROD_W          = 2 * SAMPLE_W;
  localparam int ACC_W           = 48;
  localparam int LAG_W           = 3;
  localparam int DEFAULT_MAX_LAG = 3;

  // Control bundle broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic advance;    // the whole pipeline moves this cycle
    logic shift;      // a new sample pair is taken into the delay lines
    logic clear;      // that pair closes the frame, so the delay lines restart at zero
    logic acc_valid;  // the product registers hold a pair to account for
    logic acc_en;     // that pair lies inside the summation window
    logic acc_last;   // that pair is the last one of its frame
  } cell_ctrl_t;

endpackage

@@ rtl/xcl_cell.sv @@
// One lag cell: a right-channel delay tap, a product register and a saturating accumulator.
module xcl_cell
  import xcl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cell_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] left_tap,
  input  logic signed [SAMPLE_W-1:0] right_in,
  output logic signed [SAMPLE_W-1:0] right_out,
  output logic signed [ACC_W-1:0]    snap
);

  localparam int SUM_W = ACC_W + 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  sum;
  logic signed [ACC_W-1:0]  sat_sum;
  logic signed [ACC_W-1:0]  acc_next;

  // The sum carries one guard bit; a guard bit that differs from the sign means overflow.
  always_comb begin
    sum = SUM_W'(acc) + SUM_W'(prod);
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      sat_sum = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_sum = sum[ACC_W-1:0];
    end
    acc_next = ctrl.acc_en ? sat_sum : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_out <= '0;
      acc       <= '0;
    end else if (ctrl.advance) begin
      if (ctrl.shift) begin
        right_out <= ctrl.clear ? '0 : right_in;
      end
      if (ctrl.acc_valid) begin
        acc <= ctrl.acc_last ? '0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      prod <= left_tap * right_in;
      if (ctrl.acc_valid && ctrl.acc_last) begin
        snap <= acc_next;
      end
    end
  end

endmodule

@@ rtl/xcl_peak_tree.sv @@
// Registered comparison tree that finds the largest absolute correlation and its lag index.
module xcl_peak_tree
  import xcl_pkg::*;
#(
  parameter int LAG_COUNT = 2 * DEFAULT_MAX_LAG + 1,
  parameter int IDX_W     = $clog2(LAG_COUNT)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    in_valid,
  input  logic signed [ACC_W-1:0] snap [LAG_COUNT],
  output logic                    peak_valid,
  output logic [ACC_W-1:0]        peak_mag,
  output logic [IDX_W-1:0]        peak_idx
);

  localparam int LEVELS = IDX_W;
  localparam int NPAD   = 1 << LEVELS;

  logic [ACC_W-1:0] leaf_mag [NPAD];
  logic [ACC_W-1:0] mag [LEVELS+1][NPAD];
  logic [IDX_W-1:0] idx [LEVELS+1][NPAD];
  logic [LEVELS:0]  vld;

  // Padding leaves hold zero and sit after every real lag, so they never win a tie.
  for (genvar g = 0; g < NPAD; g++) begin : g_leaf
    if (g < LAG_COUNT) begin : g_real
      assign leaf_mag[g] = snap[g][ACC_W-1] ? (~snap[g] + 1'b1) : snap[g];
    end else begin : g_pad
      assign leaf_mag[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LEVELS-1:0], in_valid};
    end
  end

  // The right-hand candidate wins only when strictly larger, keeping the earlier lag on ties.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int n = 0; n < NPAD; n++) begin
        mag[0][n] <= leaf_mag[n];
        idx[0][n] <= IDX_W'(n);
      end
      for (int l = 0; l < LEVELS; l++) begin
        for (int n = 0; n < NPAD / 2; n++) begin
          if (n < (NPAD >> (l + 1))) begin
            if (mag[l][2*n+1] > mag[l][2*n]) begin
              mag[l+1][n] <= mag[l][2*n+1];
              idx[l+1][n] <= idx[l][2*n+1];
            end else begin
              mag[l+1][n] <= mag[l][2*n];
              idx[l+1][n] <= idx[l][2*n];
            end
          end else begin
            mag[l+1][n] <= '0;
            idx[l+1][n] <= '0;
          end
        end
        for (int n = NPAD / 2; n < NPAD; n++) begin
          mag[l+1][n] <= '0;
          idx[l+1][n] <= '0;
        end
      end
    end
  end

  assign peak_valid = vld[LEVELS];
  assign peak_mag   = mag[LEVELS][0];
  assign peak_idx   = idx[LEVELS][0];

endmodule

@@ rtl/cross_correlation_lag_search.sv @@
// Top level of the cross-correlation lag search: delay lines, lag cell chain and peak search.
// Throughput: one sample pair per cycle with no gaps between frames, unless the output stalls.
// Result path: once a frame's last transaction is accepted, its result moves through the
// product register and then the accumulate, magnitude, comparison-tree and output register
// stages; a stall holds it in place.
// Reset: synchronous, active high; it clears the delay lines, accumulators, warmup count
// and all valid flags, so the first frame starts from an all-zero history.
module cross_correlation_lag_search
  import xcl_pkg::*;
#(
  parameter int MAX_LAG = DEFAULT_MAX_LAG
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] left_sample,
  input  logic signed [SAMPLE_W-1:0] right_sample,
  input  logic                       last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [LAG_W-1:0]    best_lag,
  output logic [ACC_W-1:0]           peak_magnitude
);

  localparam int LAG_COUNT = 2 * MAX_LAG + 1;
  localparam int IDX_W     = $clog2(LAG_COUNT);
  localparam int WARM_W    = $clog2(LAG_COUNT);
  localparam logic [WARM_W-1:0] WARM_FULL  = WARM_W'(2 * MAX_LAG);
  localparam logic [IDX_W:0]    LAG_OFFSET = (IDX_W + 1)'(MAX_LAG);

  // The pipeline moves on every cycle except when a finished result reaches the tail of the
  // comparison tree while the output register still holds one that has not been taken.
  logic advance;
  logic accept;

  // Left delay line holds the last MAX_LAG left samples; the oldest one is the left factor
  // of every product formed for the transaction being accepted.
  logic signed [SAMPLE_W-1:0] left_hist [MAX_LAG];
  logic [WARM_W-1:0]          warmup;

  // Flags that travel with the product registers and with the accumulator snapshots.
  logic s2_valid;
  logic s2_en;
  logic s2_last;
  logic s3_valid;

  cell_ctrl_t                 ctrl;
  logic signed [SAMPLE_W-1:0] right_chain [LAG_COUNT];
  logic signed [ACC_W-1:0]    snap_by_tap [LAG_COUNT];
  logic signed [ACC_W-1:0]    snap_by_lag [LAG_COUNT];

  logic                       peak_valid;
  logic [ACC_W-1:0]           peak_mag;
  logic [IDX_W-1:0]           peak_idx;
  logic [IDX_W:0]             lag_diff;

  assign advance  = !(out_valid && !out_ready && peak_valid);
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  assign ctrl.advance   = advance;
  assign ctrl.shift     = accept;
  assign ctrl.clear     = last_sample;
  assign ctrl.acc_valid = s2_valid;
  assign ctrl.acc_en    = s2_en;
  assign ctrl.acc_last  = s2_last;

  // Cell j sees right_history[j] as it stands after the shift: the new right sample for the
  // first cell, and the tap of its neighbor for every other one. Cell j sums lag MAX_LAG - j.
  assign right_chain[0] = right_sample;

  for (genvar j = 0; j < LAG_COUNT; j++) begin : g_cell
    if (j < LAG_COUNT - 1) begin : g_mid
      xcl_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .left_tap  (left_hist[MAX_LAG-1]),
        .right_in  (right_chain[j]),
        .right_out (right_chain[j+1]),
        .snap      (snap_by_tap[j])
      );
    end else begin : g_end
      xcl_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .left_tap  (left_hist[MAX_LAG-1]),
        .right_in  (right_chain[j]),
        .right_out (),
        .snap      (snap_by_tap[j])
      );
    end
    assign snap_by_lag[LAG_COUNT-1-j] = snap_by_tap[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_en    <= 1'b0;
      s2_last  <= 1'b0;
      s3_valid <= 1'b0;
      warmup   <= '0;
      for (int k = 0; k < MAX_LAG; k++) begin
        left_hist[k] <= '0;
      end
    end else if (advance) begin
      s2_valid <= accept;
      s2_en    <= (warmup == WARM_FULL);
      s2_last  <= last_sample;
      s3_valid <= s2_valid && s2_last;
      if (accept) begin
        // A closing transaction restarts the frame: warmup and history go back to zero.
        if (last_sample) begin
          warmup <= '0;
          for (int k = 0; k < MAX_LAG; k++) begin
            left_hist[k] <= '0;
          end
        end else begin
          if (warmup != WARM_FULL) begin
            warmup <= warmup + 1'b1;
          end
          left_hist[0] <= left_sample;
          for (int k = 1; k < MAX_LAG; k++) begin
            left_hist[k] <= left_hist[k-1];
          end
        end
      end
    end
  end

  xcl_peak_tree #(
    .LAG_COUNT (LAG_COUNT),
    .IDX_W     (IDX_W)
  ) u_peak_tree (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (s3_valid),
    .snap       (snap_by_lag),
    .peak_valid (peak_valid),
    .peak_mag   (peak_mag),
    .peak_idx   (peak_idx)
  );

  // When every sum is zero the winner is lag zero, whatever index the tree kept.
  assign lag_diff = {1'b0, peak_idx} - LAG_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && peak_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && peak_valid) begin
      best_lag       <= (peak_mag == '0) ? '0 : lag_diff[LAG_W-1:0];
      peak_magnitude <= peak_mag;
    end
  end

endmodule

@@ rtl/xcl_checker.sv @@
// Port-level checker for the cross-correlation lag search, bound to the top level.
module xcl_checker
  import xcl_pkg::*;
#(
  parameter int MAX_LAG = DEFAULT_MAX_LAG
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [LAG_W-1:0]    best_lag,
  input logic [ACC_W-1:0]           peak_magnitude
);

  // A result that waits keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_lag) && $stable(peak_magnitude))
    else $error("result changed while stalled");

  // With no result waiting, the input side can never be blocked.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output register");

  // A frame whose sums are all zero reports lag zero.
  a_zero_lag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (peak_magnitude == '0) |-> (best_lag == '0))
    else $error("zero magnitude with nonzero lag");

  // Saturated sums never exceed two to the 47th in magnitude.
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && peak_magnitude[ACC_W-1] |-> (peak_magnitude[ACC_W-2:0] == '0))
    else $error("magnitude beyond saturation range");

  // Lags stay in the reportable range when the field can hold them all.
  a_lag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (MAX_LAG > 3) || (best_lag != 3'b100))
    else $error("lag outside search window");

endmodule

bind cross_correlation_lag_search xcl_checker #(
  .MAX_LAG (MAX_LAG)
) u_xcl_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .best_lag       (best_lag),
  .peak_magnitude (peak_magnitude)
);
